@@ rtl/adaptive_trimmed_mean_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive trimmed mean filter
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TRIMMED_MEAN_FILTER_ASSERT_SVH
`define ADAPTIVE_TRIMMED_MEAN_FILTER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ATMF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ATMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/atmf_pkg.sv @@
// ----------------------------------------------------------------------------
// atmf_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package atmf_pkg;

  localparam int DEPTH      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 4;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (WIN_W > CNT_W) ? WIN_W : CNT_W;
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WINDOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WINDOW       = 3'd4;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST   = 16'd240;
  localparam logic [SAMPLE_W-1:0] MEDIUM_THRESHOLD_RST = 16'd120;
  localparam logic [WIN_W-1:0]    HIGH_WINDOW_RST      = 4'd8;
  localparam logic [WIN_W-1:0]    MEDIUM_WINDOW_RST    = 4'd4;
  localparam logic [WIN_W-1:0]    LOW_WINDOW_RST       = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_TRIM,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_threshold;
    logic [SAMPLE_W-1:0] medium_threshold;
    logic [WIN_W-1:0]    high_window;
    logic [WIN_W-1:0]    medium_window;
    logic [WIN_W-1:0]    low_window;
  } cfg_t;

  typedef struct packed {
    logic start;     // store the sample and set up the window
    logic rd;        // read the next ring entry
    logic acc;       // fold the read entry into sum, min and max
    logic trim;      // drop min and max, load the divider
    logic div_step;  // one restoring division step
    logic load_out;  // move the quotient to the output register
  } cmd_t;

  typedef struct packed {
    logic acc_last;
    logic div_last;
  } status_t;

endpackage

@@ rtl/atmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// atmf_ctrl
// Sequencer that steps the datapath through store, sum, trim, divide and output load.
// ----------------------------------------------------------------------------
module atmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  atmf_pkg::status_t status,
  output logic              in_ready,
  output atmf_pkg::cmd_t    cmd
);

  atmf_pkg::state_t state;
  atmf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      atmf_pkg::ST_IDLE: begin
        if (in_valid) state_next = atmf_pkg::ST_READ;
      end
      atmf_pkg::ST_READ: begin
        state_next = atmf_pkg::ST_ACCUM;
      end
      atmf_pkg::ST_ACCUM: begin
        state_next = status.acc_last ? atmf_pkg::ST_TRIM : atmf_pkg::ST_READ;
      end
      atmf_pkg::ST_TRIM: begin
        state_next = atmf_pkg::ST_DIVIDE;
      end
      atmf_pkg::ST_DIVIDE: begin
        if (status.div_last) state_next = atmf_pkg::ST_DONE;
      end
      atmf_pkg::ST_DONE: begin
        if (out_free) state_next = atmf_pkg::ST_IDLE;
      end
      default: begin
        state_next = atmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      atmf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      atmf_pkg::ST_READ:   cmd.rd       = 1'b1;
      atmf_pkg::ST_ACCUM:  cmd.acc      = 1'b1;
      atmf_pkg::ST_TRIM:   cmd.trim     = 1'b1;
      atmf_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      atmf_pkg::ST_DONE:   cmd.load_out = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/atmf_dp.sv @@
// ----------------------------------------------------------------------------
// atmf_dp
// Sample ring, window sizing, running sum with min/max, serial divider.
// ----------------------------------------------------------------------------
module atmf_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  atmf_pkg::cfg_t                   cfg,
  input  logic [atmf_pkg::SAMPLE_W-1:0]    sample,
  input  atmf_pkg::cmd_t                   cmd,
  output atmf_pkg::status_t                status,
  output logic [atmf_pkg::SAMPLE_W-1:0]    quotient
);

  logic [atmf_pkg::SAMPLE_W-1:0] ring [atmf_pkg::DEPTH];
  logic [atmf_pkg::SAMPLE_W-1:0] rd_data;

  logic [atmf_pkg::PTR_W-1:0]    wp;
  logic [atmf_pkg::PTR_W-1:0]    rp;
  logic [atmf_pkg::CNT_W-1:0]    fill_count;
  logic [atmf_pkg::CNT_W-1:0]    n;
  logic [atmf_pkg::CNT_W-1:0]    k;
  logic [atmf_pkg::SUM_W-1:0]    sum;
  logic [atmf_pkg::SAMPLE_W-1:0] mx;
  logic [atmf_pkg::SAMPLE_W-1:0] mn;
  logic [atmf_pkg::SUM_W-1:0]    dq;
  logic [atmf_pkg::CNT_W-1:0]    rem;
  logic [atmf_pkg::STEP_W-1:0]   step;

  logic [atmf_pkg::CNT_W-1:0]    fill_next;
  logic [atmf_pkg::WIN_W-1:0]    win_sel;
  logic [atmf_pkg::WIN_W-1:0]    win_nz;
  logic [atmf_pkg::CMP_W-1:0]    win_ext;
  logic [atmf_pkg::CMP_W-1:0]    fill_ext;
  logic [atmf_pkg::CNT_W-1:0]    n_next;
  logic [atmf_pkg::CNT_W:0]      rem_sh;
  logic [atmf_pkg::CNT_W:0]      rem_diff;
  logic                          rem_ge;

  // Window size from the new sample, cut to the updated fill count.
  always_comb begin
    fill_next = (fill_count < atmf_pkg::CNT_W'(atmf_pkg::DEPTH)) ?
                fill_count + 1'b1 : fill_count;
    if (sample >= cfg.high_threshold) begin
      win_sel = cfg.high_window;
    end else if (sample >= cfg.medium_threshold) begin
      win_sel = cfg.medium_window;
    end else begin
      win_sel = cfg.low_window;
    end
    win_nz   = (win_sel == '0) ? atmf_pkg::WIN_W'(1) : win_sel;
    win_ext  = atmf_pkg::CMP_W'(win_nz);
    fill_ext = atmf_pkg::CMP_W'(fill_next);
    n_next   = (win_ext > fill_ext) ? fill_next : win_ext[atmf_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) ring[wp] <= sample;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data <= ring[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill_count <= '0;
    end else if (cmd.start) begin
      wp         <= (wp == atmf_pkg::PTR_W'(atmf_pkg::DEPTH - 1)) ? '0 : wp + 1'b1;
      fill_count <= fill_next;
    end
  end

  // Walk from the newest entry backward through the ring.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rp  <= wp;
      n   <= n_next;
      k   <= '0;
      sum <= '0;
      mx  <= '0;
      mn  <= '1;
    end else if (cmd.acc) begin
      rp  <= (rp == '0) ? atmf_pkg::PTR_W'(atmf_pkg::DEPTH - 1) : rp - 1'b1;
      k   <= k + 1'b1;
      sum <= sum + atmf_pkg::SUM_W'(rd_data);
      if (rd_data > mx) mx <= rd_data;
      if (rd_data < mn) mn <= rd_data;
    end else if (cmd.trim) begin
      if (n > atmf_pkg::CNT_W'(2)) begin
        n <= n - atmf_pkg::CNT_W'(2);
      end
    end
  end

  assign rem_sh   = {rem, dq[atmf_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, n};
  assign rem_ge   = (rem_sh >= {1'b0, n});

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      rem  <= '0;
      step <= '0;
      if (n > atmf_pkg::CNT_W'(2)) begin
        dq <= sum - atmf_pkg::SUM_W'(mx) - atmf_pkg::SUM_W'(mn);
      end else begin
        dq <= sum;
      end
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (rem_ge) begin
        rem <= rem_diff[atmf_pkg::CNT_W-1:0];
        dq  <= {dq[atmf_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[atmf_pkg::CNT_W-1:0];
        dq  <= {dq[atmf_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign status.acc_last = (atmf_pkg::CNT_W'(k + 1'b1) == n);
  assign status.div_last = (step == atmf_pkg::STEP_W'(atmf_pkg::SUM_W - 1));
  assign quotient        = dq[atmf_pkg::SAMPLE_W-1:0];

endmodule

@@ rtl/adaptive_trimmed_mean_filter.sv @@
// Window: n is the window after the cut to the fill count (1 to DEPTH). The
//   ring has a single read port, walked one entry at a time, and the divider
//   is bit-serial; a new transaction is taken only after the previous result
//   is loaded into the output register.
// Reset: synchronous, active high; clears pointer, fill count, controller and
//   output valid, and loads the register reset values. Ring contents are kept.
// ----------------------------------------------------------------------------
// adaptive_trimmed_mean_filter
// Trimmed mean of the newest samples, with a window chosen from sample value.
// ----------------------------------------------------------------------------
`include "adaptive_trimmed_mean_filter_assert.svh"

module adaptive_trimmed_mean_filter (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [atmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atmf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Sample input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [atmf_pkg::SAMPLE_W-1:0]      sample,
  // Filtered output channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [atmf_pkg::SAMPLE_W-1:0]      filtered_value
);

  atmf_pkg::cfg_t    cfg;
  atmf_pkg::cmd_t    cmd;
  atmf_pkg::status_t status;
  logic [atmf_pkg::SAMPLE_W-1:0] quotient;
  logic              out_free;

  // Configuration registers. Writes to unused indexes fall through the
  // default arm and change nothing. Threshold registers take the full data
  // word; window registers keep only their low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold   <= atmf_pkg::HIGH_THRESHOLD_RST;
      cfg.medium_threshold <= atmf_pkg::MEDIUM_THRESHOLD_RST;
      cfg.high_window      <= atmf_pkg::HIGH_WINDOW_RST;
      cfg.medium_window    <= atmf_pkg::MEDIUM_WINDOW_RST;
      cfg.low_window       <= atmf_pkg::LOW_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        atmf_pkg::REG_HIGH_THRESHOLD:
          cfg.high_threshold <= cfg_wdata[atmf_pkg::SAMPLE_W-1:0];
        atmf_pkg::REG_MEDIUM_THRESHOLD:
          cfg.medium_threshold <= cfg_wdata[atmf_pkg::SAMPLE_W-1:0];
        atmf_pkg::REG_HIGH_WINDOW:
          cfg.high_window <= cfg_wdata[atmf_pkg::WIN_W-1:0];
        atmf_pkg::REG_MEDIUM_WINDOW:
          cfg.medium_window <= cfg_wdata[atmf_pkg::WIN_W-1:0];
        atmf_pkg::REG_LOW_WINDOW:
          cfg.low_window <= cfg_wdata[atmf_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller only sequences; all arithmetic and the ring live in the
  // datapath. The output slot is free when it is empty or being drained in
  // this cycle, so a finished result is loaded even while the previous one is drained.
  assign out_free = !out_valid || out_ready;

  atmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  atmf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .sample   (sample),
    .cmd      (cmd),
    .status   (status),
    .quotient (quotient)
  );

  // Output register. It holds a result while the consumer stalls, and the
  // controller returns to idle as soon as the result is loaded, so a new
  // sample can be taken while the previous result still waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) filtered_value <= quotient;
  end

  // A result is only loaded into a free output slot.
  `ATMF_ASSERT_SAME(a_load_into_free, clk, rst, cmd.load_out, out_free, "output overwritten")
  // An accepted transaction makes the controller busy and starts the ring walk.
  `ATMF_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready && cmd.rd, "no walk after accept")
  // The walk never stops mid-window: an accumulate step is followed by a read or a trim.
  `ATMF_ASSERT_NEXT(a_walk_continues, clk, rst, cmd.acc, cmd.rd || cmd.trim, "ring walk broken")

endmodule
